>>> rtl/fcsd_pkg.sv
// Front-coded string decoder: shared commands, error codes, state and result types.
// No dependencies; imported by every module of the decoder.
`default_nettype none

package fcsd_pkg;

   localparam logic [1:0] CMD_HEADER = 2'd0;
   localparam logic [1:0] CMD_SUFFIX = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_PREFIX     = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW   = 2'd2;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd3;

   localparam int LEN_W = 7;

   typedef enum logic [0:0] {
      ST_IDLE   = 1'b0,
      ST_PREFIX = 1'b1
   } fcsd_state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       empty_res;
      logic [1:0] error;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/fcsd_store.sv
// String store: single-port-write, single-port-read synchronous memory.
// Read data is registered and held until the next read; uses fcsd_pkg.
`default_nettype none

module fcsd_store
   import fcsd_pkg::*;
#(
   parameter int MAX_LEN = 64,
   parameter int ADDR_W  = 6
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [7:0]        rd_data
);

   logic [7:0] mem [MAX_LEN];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/fcsd_rsp_buf.sv
// Two-entry result buffer between the decoder and the rsp_ channel.
// Holds result beats while the consumer stalls; uses fcsd_pkg.
`default_nettype none

module fcsd_rsp_buf
   import fcsd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output      logic    room,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   rsp_type    entry_ff [2];
   logic       head_ff, head_in;
   logic       tail_ff, tail_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = entry_ff[head_ff];
   assign room      = (count_ff != 2'd2);
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      head_in  = pop  ? ~head_ff : head_ff;
      tail_in  = push ? ~tail_ff : tail_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/front_coded_string_decoder_core.sv
// Front-coded string decoder top level: control, string store and result buffer.
// Depends on fcsd_pkg, fcsd_store and fcsd_rsp_buf.
//
// Each string arrives as a header beat (prefix and suffix length) and then its
// suffix bytes, one beat each. A good header with a nonzero prefix length P
// reads the P shared bytes back from the string store, one per cycle while the
// result buffer has room. The last read then passes through the store's read
// register into the result buffer before the next beat is taken. A two-entry
// result buffer lets input continue while the rsp_ side stalls, until it fills.
// No clearing pass is needed after reset.
`default_nettype none

module front_coded_string_decoder_core
   import fcsd_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [1:0] req_command,
   input  wire logic [6:0] req_prefix_len,
   input  wire logic [6:0] req_suffix_len,
   input  wire logic [7:0] req_data_byte,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [7:0] rsp_out_byte,
   output      logic       rsp_last,
   output      logic       rsp_empty_res,
   output      logic [1:0] rsp_error
);

   localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam logic [LEN_W:0]   MAX_SUM = (LEN_W + 1)'(MAX_LEN);
   localparam logic [LEN_W-1:0] MAX_POS = LEN_W'(MAX_LEN);

   fcsd_state_type   state_ff, state_in;
   logic [LEN_W-1:0] prior_len_ff, prior_len_in;
   logic [LEN_W-1:0] wr_pos_ff, wr_pos_in;
   logic [LEN_W-1:0] sfx_rem_ff, sfx_rem_in;
   logic             drop_ff, drop_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] plen_ff, plen_in;
   logic             fin_ff, fin_in;
   logic             pend_ff, pend_in;
   logic             pend_last_ff, pend_last_in;

   logic             accept;
   logic             abort;
   logic             room;
   logic             push;
   rsp_type          push_data;
   rsp_type          rsp_data;
   logic             wr_en;
   logic             rd_en;
   logic [7:0]       rd_data;
   logic [LEN_W:0]   len_sum;
   logic [LEN_W-1:0] idx_next;

   assign req_ready = (state_ff == ST_IDLE) && !pend_ff && room;
   assign accept    = req_valid && req_ready;
   assign len_sum   = {1'b0, req_prefix_len} + {1'b0, req_suffix_len};
   assign idx_next  = idx_ff + LEN_W'(1);

   always_comb begin
      state_in     = state_ff;
      prior_len_in = prior_len_ff;
      wr_pos_in    = wr_pos_ff;
      sfx_rem_in   = sfx_rem_ff;
      drop_in      = drop_ff;
      idx_in       = idx_ff;
      plen_in      = plen_ff;
      fin_in       = fin_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      abort        = 1'b0;
      push         = 1'b0;
      push_data    = '0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      // drain the pending store read into the result buffer
      if (pend_ff && room) begin
         push      = 1'b1;
         push_data = '{out_byte: rd_data, last: pend_last_ff, empty_res: 1'b0,
                       error: ERR_NONE};
         pend_in   = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_SUFFIX) begin
                  if (sfx_rem_ff == '0) begin
                     abort = 1'b1;
                  end else begin
                     sfx_rem_in = sfx_rem_ff - LEN_W'(1);
                     if (drop_ff) begin
                        if (sfx_rem_ff == LEN_W'(1)) begin
                           drop_in = 1'b0;
                        end
                     end else begin
                        wr_en     = (wr_pos_ff < MAX_POS);
                        wr_pos_in = wr_pos_ff + LEN_W'(1);
                        push      = 1'b1;
                        push_data = '{out_byte: req_data_byte,
                                      last: (sfx_rem_ff == LEN_W'(1)),
                                      empty_res: 1'b0, error: ERR_NONE};
                        if (sfx_rem_ff == LEN_W'(1)) begin
                           prior_len_in = wr_pos_ff + LEN_W'(1);
                        end
                     end
                  end
               end else if (req_command != CMD_HEADER && req_command != CMD_CLEAR) begin
                  abort = 1'b1;
               end else if (sfx_rem_ff != '0) begin
                  abort = 1'b1;
               end else if (req_command == CMD_CLEAR) begin
                  prior_len_in = '0;
                  wr_pos_in    = '0;
               end else if (len_sum > MAX_SUM) begin
                  push       = 1'b1;
                  push_data  = '{out_byte: 8'd0, last: 1'b1, empty_res: 1'b0,
                                 error: ERR_OVERFLOW};
                  sfx_rem_in = req_suffix_len;
                  drop_in    = (req_suffix_len != '0);
               end else if (req_prefix_len > prior_len_ff) begin
                  push       = 1'b1;
                  push_data  = '{out_byte: 8'd0, last: 1'b1, empty_res: 1'b0,
                                 error: ERR_PREFIX};
                  sfx_rem_in = req_suffix_len;
                  drop_in    = (req_suffix_len != '0);
               end else if (req_prefix_len == '0 && req_suffix_len == '0) begin
                  prior_len_in = '0;
                  wr_pos_in    = '0;
                  push         = 1'b1;
                  push_data    = '{out_byte: 8'd0, last: 1'b1, empty_res: 1'b1,
                                   error: ERR_NONE};
               end else begin
                  wr_pos_in    = req_prefix_len;
                  prior_len_in = req_prefix_len;
                  sfx_rem_in   = req_suffix_len;
                  drop_in      = 1'b0;
                  if (req_prefix_len != '0) begin
                     state_in = ST_PREFIX;
                     idx_in   = '0;
                     plen_in  = req_prefix_len;
                     fin_in   = (req_suffix_len == '0);
                  end
               end
            end
         end
         ST_PREFIX: begin
            // advance one store read whenever the read register is free
            if (!pend_ff || room) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_last_in = fin_ff && (idx_next == plen_ff);
               idx_in       = idx_next;
               if (idx_next == plen_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // drop the pending string and empty the previous one
      if (abort) begin
         sfx_rem_in   = '0;
         drop_in      = 1'b0;
         prior_len_in = '0;
         wr_pos_in    = '0;
         push         = 1'b1;
         push_data    = '{out_byte: 8'd0, last: 1'b1, empty_res: 1'b0,
                          error: ERR_UNEXPECTED};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prior_len_ff <= '0;
         wr_pos_ff    <= '0;
         sfx_rem_ff   <= '0;
         drop_ff      <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prior_len_ff <= prior_len_in;
         wr_pos_ff    <= wr_pos_in;
         sfx_rem_ff   <= sfx_rem_in;
         drop_ff      <= drop_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      plen_ff      <= plen_in;
      fin_ff       <= fin_in;
      pend_last_ff <= pend_last_in;
   end

   fcsd_store #(
      .MAX_LEN (MAX_LEN),
      .ADDR_W  (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_pos_ff[ADDR_W-1:0]),
      .wr_data (req_data_byte),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   fcsd_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_byte  = rsp_data.out_byte;
   assign rsp_last      = rsp_data.last;
   assign rsp_empty_res = rsp_data.empty_res;
   assign rsp_error     = rsp_data.error;

endmodule

`default_nettype wire
